FILE: rtl/core/apq_pkg.sv
`timescale 1ns / 1ps
package apq_pkg;

  // Field widths
  localparam int unsigned ID_W    = 16;
  localparam int unsigned PRI_W   = 2;
  localparam int unsigned WAIT_W  = 16;
  localparam int unsigned INC_W   = 12;
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Default queue depth
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

  // Priority levels
  localparam logic [PRI_W-1:0] PRI_NONE = 2'd0;
  localparam logic [PRI_W-1:0] PRI_LOW  = 2'd1;
  localparam logic [PRI_W-1:0] PRI_MID  = 2'd2;
  localparam logic [PRI_W-1:0] PRI_HIGH = 2'd3;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_THR = 1'd1;
  localparam logic [THR_W-1:0] LOW_THR_RST = 16'd32;
  localparam logic [THR_W-1:0] MID_THR_RST = 16'd96;

  // One queued job
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic [WAIT_W-1:0] wait_val;
  } cell_data_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic              insert;
    logic              remove;
    logic              tick;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic [INC_W-1:0]  inc;
    logic [THR_W-1:0]  low_thr;
    logic [THR_W-1:0]  mid_thr;
    logic [PRI_W-1:0]  max_pri;
  } cell_cmd_t;

endpackage

FILE: rtl/core/aging_priority_queue_core.sv
`timescale 1ns / 1ps
// Priority queue of jobs with three levels and aging.
// Input channel (in_valid / in_stall): one request per item, in_mode selects
// insert (job id and priority), remove (highest priority, oldest first) or
// tick (add in_wait_increment to every queued job, then promote by one level
// against the two thresholds).
// Result channel (out_valid / out_stall): one result per request, carrying
// the removed job, job_valid, rejected and the occupancy after the request.
// Config channel (cfg_valid / cfg_ready): cfg_index 0 writes the low
// promotion threshold, 1 the mid threshold; write only while idle.
// Timing: a request is taken into the request register, the cell row
// executes it once the result register is free, and the result register
// then shows it. One request is held at a time, so no new request is taken
// until the held one has executed; the request register is the limit.
// Reset empties the queue at once (valid bits per cell) and restores the
// thresholds to 32 and 96. While the receiver stalls, the result register
// holds; a request already taken waits in the request register and in_stall
// stays high until the result register frees.
module aging_priority_queue_core
  import apq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [ID_W-1:0]      in_job_id,
  input  logic [PRI_W-1:0]     in_job_priority,
  input  logic [INC_W-1:0]     in_wait_increment,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ID_W-1:0]      out_job_id,
  output logic [PRI_W-1:0]     out_priority,
  output logic [WAIT_W-1:0]    out_wait,
  output logic                 out_job_valid,
  output logic                 out_rejected,
  output logic [OCC_W-1:0]     out_occupancy,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Request register
  logic              busy_r, busy_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [ID_W-1:0]   id_r;
  logic [PRI_W-1:0]  pri_r;
  logic [INC_W-1:0]  inc_r;

  // Thresholds and count
  logic [THR_W-1:0] low_thr_r, low_thr_nxt;
  logic [THR_W-1:0] mid_thr_r, mid_thr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  cell_data_t        res_data_r, res_data_nxt;
  logic              res_job_valid_r, res_job_valid_nxt;
  logic              res_rej_r, res_rej_nxt;
  logic [OCC_W-1:0]  res_occ_r, res_occ_nxt;

  // Cell row
  cell_cmd_t  cmd;
  logic       cell_valid [QUEUE_DEPTH];
  cell_data_t cell_data  [QUEUE_DEPTH];
  logic       cell_found [QUEUE_DEPTH];
  logic       cell_sel   [QUEUE_DEPTH];

  logic       accept, fire, full, empty, any_high, any_mid;
  cell_data_t sel_data;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = busy_r;
  assign fire      = busy_r && (!out_valid_r || !out_stall);
  assign full      = cell_valid[QUEUE_DEPTH-1];
  assign empty     = !cell_valid[0];
  assign cfg_ready = 1'b1;

  // Find the top priority present and mux out the selected job
  always_comb begin
    any_high = 1'b0;
    any_mid  = 1'b0;
    sel_data = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      any_high = any_high | (cell_valid[i] && cell_data[i].pri == PRI_HIGH);
      any_mid  = any_mid  | (cell_valid[i] && cell_data[i].pri == PRI_MID);
      sel_data = sel_data | (cell_sel[i] ? cell_data[i] : '0);
    end
  end

  // Broadcast the command
  always_comb begin
    cmd         = '0;
    cmd.id      = id_r;
    cmd.pri     = pri_r;
    cmd.inc     = inc_r;
    cmd.low_thr = low_thr_r;
    cmd.mid_thr = mid_thr_r;
    cmd.max_pri = any_high ? PRI_HIGH : (any_mid ? PRI_MID : PRI_LOW);
    if (fire) begin
      unique case (mode_r)
        MODE_INSERT: cmd.insert = 1'b1;
        MODE_REMOVE: cmd.remove = 1'b1;
        MODE_TICK:   cmd.tick   = 1'b1;
        default:     ;
      endcase
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic       prev_valid, found_in, next_valid;
    cell_data_t next_data;
    if (g == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign found_in   = 1'b0;
    end else begin : g_body
      assign prev_valid = cell_valid[g-1];
      assign found_in   = cell_found[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_data  = '0;
    end else begin : g_inner
      assign next_valid = cell_valid[g+1];
      assign next_data  = cell_data[g+1];
    end
    apq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_valid (prev_valid),
      .found_in   (found_in),
      .next_valid (next_valid),
      .next_data  (next_data),
      .valid      (cell_valid[g]),
      .data       (cell_data[g]),
      .found_out  (cell_found[g]),
      .sel        (cell_sel[g])
    );
  end

  // Build the result and the new count
  always_comb begin
    count_nxt         = count_r;
    res_data_nxt      = res_data_r;
    res_job_valid_nxt = res_job_valid_r;
    res_rej_nxt       = res_rej_r;
    res_occ_nxt       = res_occ_r;
    if (fire) begin
      res_data_nxt      = '0;
      res_job_valid_nxt = 1'b0;
      res_rej_nxt       = 1'b0;
      unique case (mode_r)
        MODE_INSERT: begin
          if (full) begin
            res_rej_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        MODE_REMOVE: begin
          if (empty) begin
            res_rej_nxt = 1'b1;
          end else begin
            count_nxt         = count_r - CNT_W'(1);
            res_data_nxt      = sel_data;
            res_job_valid_nxt = 1'b1;
          end
        end
        default: ;
      endcase
      res_occ_nxt = OCC_W'(count_nxt);
    end
  end

  // Hold the result until taken and track the pending request
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (fire) begin
      busy_nxt = 1'b0;
    end
  end

  // Decode configuration writes
  always_comb begin
    low_thr_nxt = low_thr_r;
    mid_thr_nxt = mid_thr_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOW_THR: low_thr_nxt = cfg_data;
        CFG_MID_THR: mid_thr_nxt = cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      low_thr_r   <= LOW_THR_RST;
      mid_thr_r   <= MID_THR_RST;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      low_thr_r   <= low_thr_nxt;
      mid_thr_r   <= mid_thr_nxt;
    end
  end

  // Capture the request and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      id_r   <= in_job_id;
      pri_r  <= in_job_priority;
      inc_r  <= in_wait_increment;
    end
    res_data_r      <= res_data_nxt;
    res_job_valid_r <= res_job_valid_nxt;
    res_rej_r       <= res_rej_nxt;
    res_occ_r       <= res_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_job_id    = res_data_r.id;
  assign out_priority  = res_data_r.pri;
  assign out_wait      = res_data_r.wait_val;
  assign out_job_valid = res_job_valid_r;
  assign out_rejected  = res_rej_r;
  assign out_occupancy = res_occ_r;

endmodule

FILE: rtl/core/apq_cell.sv
`timescale 1ns / 1ps
module apq_cell
  import apq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_cmd_t  cmd,
  input  logic       prev_valid,
  input  logic       found_in,
  input  logic       next_valid,
  input  cell_data_t next_data,
  output logic       valid,
  output cell_data_t data,
  output logic       found_out,
  output logic       sel
);

  logic       valid_r, valid_nxt;
  cell_data_t data_r, data_nxt;
  logic       match;
  logic [WAIT_W:0]   sum;
  logic [WAIT_W-1:0] wait_sat;

  // Pick the oldest job at the top priority
  assign match     = valid_r && (data_r.pri == cmd.max_pri);
  assign sel       = match && !found_in;
  assign found_out = found_in || match;

  // Age with saturation
  assign sum      = {1'b0, data_r.wait_val} + {{(WAIT_W + 1 - INC_W){1'b0}}, cmd.inc};
  assign wait_sat = sum[WAIT_W] ? {WAIT_W{1'b1}} : sum[WAIT_W-1:0];

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (cmd.insert) begin
      // Load the first empty cell
      if (!valid_r && prev_valid) begin
        valid_nxt        = 1'b1;
        data_nxt.id      = cmd.id;
        data_nxt.pri     = (cmd.pri == PRI_NONE) ? PRI_LOW : cmd.pri;
        data_nxt.wait_val = '0;
      end
    end else if (cmd.remove) begin
      // Close the gap: take the right neighbor from the removed job onward
      if (found_out) begin
        valid_nxt = next_valid;
        data_nxt  = next_data;
      end
    end else if (cmd.tick) begin
      if (valid_r) begin
        data_nxt.wait_val = wait_sat;
        if (data_r.pri == PRI_LOW && wait_sat >= cmd.low_thr) begin
          data_nxt.pri = PRI_MID;
        end else if (data_r.pri == PRI_MID && wait_sat >= cmd.mid_thr) begin
          data_nxt.pri = PRI_HIGH;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

FILE: rtl/core/apq_checker.sv
`timescale 1ns / 1ps
module apq_checker
  import apq_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [MODE_W-1:0]    in_mode,
  input logic [ID_W-1:0]      in_job_id,
  input logic [PRI_W-1:0]     in_job_priority,
  input logic [INC_W-1:0]     in_wait_increment,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [ID_W-1:0]      out_job_id,
  input logic [PRI_W-1:0]     out_priority,
  input logic [WAIT_W-1:0]    out_wait,
  input logic                 out_job_valid,
  input logic                 out_rejected,
  input logic [OCC_W-1:0]     out_occupancy,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [THR_W-1:0]     cfg_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_job_id) && $stable(out_occupancy))
    else $error("stalled result changed");

  // Take one request at a time
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is pending");

  // A returned job is never also a reject and carries a real priority
  a_job_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_job_valid |-> !out_rejected && out_priority != PRI_NONE)
    else $error("returned job with bad flags");

  // No job means zeroed job fields
  a_no_job_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_job_valid |-> out_job_id == '0 && out_wait == '0 &&
                                    out_priority == PRI_NONE)
    else $error("job fields set without a job");

endmodule

bind aging_priority_queue_core apq_checker u_apq_checker (.*);
